[rtl/bpfa_pkg.sv]
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants of the bitmap page-frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  // field widths of the transaction payload
  localparam int ADDR_W     = 52;
  localparam int LEN_W      = 52;
  localparam int FRAME_W    = 40;
  localparam int PAGE_SHIFT = 12;
  localparam int USED_W     = 17;
  localparam int LEFT_W     = 13;
  localparam int WORD_W     = 64;

  // default geometry
  localparam int MAX_REGIONS_DEF  = 16;
  localparam int REGION_PAGES_DEF = 4096;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_COUNT = 2'd3
  } bpfa_op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } bpfa_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_FILL,
    S_ALLOC_REGION,
    S_ALLOC_READ,
    S_ALLOC_CHECK,
    S_FREE_SCAN,
    S_FREE_READ,
    S_FREE_WRITE
  } bpfa_state_t;

endpackage

[rtl/bpfa_req_if.sv]
// ----------------------------------------------------------------------------
// bpfa_req_if
// Request channel of the page-frame allocator: opcode, address and length.
// ----------------------------------------------------------------------------
interface bpfa_req_if;
  import bpfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  length;

  modport source (output valid, output opcode, output address, output length, input ready);
  modport sink   (input valid, input opcode, input address, input length, output ready);
endinterface

[rtl/bpfa_rsp_if.sv]
// ----------------------------------------------------------------------------
// bpfa_rsp_if
// Response channel of the page-frame allocator: one result per request.
// ----------------------------------------------------------------------------
interface bpfa_rsp_if;
  import bpfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] page_address;
  logic [USED_W-1:0] used_pages;
  logic [LEFT_W-1:0] leftover_bytes;

  modport source (output valid, output status, output page_address, output used_pages,
                  output leftover_bytes, input ready);
  modport sink   (input valid, input status, input page_address, input used_pages,
                  input leftover_bytes, output ready);
endinterface

[rtl/bitmap_page_frame_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit 4 KB page-frame allocator over a used-bit map held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one request per transaction (add region, allocate, free,
//   count); out_chan returns exactly one response per request, in order.
//   The used-bit map is a single-port RAM of 64-bit words, REGION_PAGES/64
//   words per region (REGION_PAGES must be a multiple of 64); each word is
//   read into a register, then modified and written back.
//   A count, or an add to a full table, is answered straight from idle. An
//   add writes every map word of the new region once. An allocate visits
//   the regions in order and reads, then checks, one word at a time from
//   the hint up. A free compares the regions in order, then reads the word
//   and clears the page's bit if it is set; it answers not found once all
//   regions are compared.
//   A request is taken only when the block is idle and the response register
//   is empty, so one request is in flight at a time. A stalled receiver holds
//   the response and blocks new requests. Reset empties the region table and
//   the used count; the map needs no clearing pass since adding a region
//   rewrites all of its words.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator #(
  parameter int MAX_REGIONS  = bpfa_pkg::MAX_REGIONS_DEF,
  parameter int REGION_PAGES = bpfa_pkg::REGION_PAGES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  bpfa_req_if.sink   in_chan,
  bpfa_rsp_if.source out_chan
);
  import bpfa_pkg::*;

  localparam int WPR       = REGION_PAGES / WORD_W;
  localparam int MAP_WORDS = MAX_REGIONS * WPR;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int RIW       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int RCW       = $clog2(MAX_REGIONS + 1);
  localparam int PW        = $clog2(REGION_PAGES);
  localparam int PCW       = PW + 1;
  localparam int WCW       = PCW - 6;
  localparam int TW        = $clog2(MAX_REGIONS * REGION_PAGES + 1);
  localparam logic [WORD_W-1:0] ONES = '1;

  // region table
  logic [FRAME_W-1:0] base_r [MAX_REGIONS];
  logic [PCW-1:0]     pcnt_r [MAX_REGIONS];
  logic [PCW-1:0]     resv_r [MAX_REGIONS];
  logic [PW-1:0]      hint_r [MAX_REGIONS];
  logic [RCW-1:0]     nreg_r, nreg_nxt;
  logic [TW-1:0]      total_r, total_nxt;

  // per-request working registers
  bpfa_state_t        state_r, state_nxt;
  logic [RCW-1:0]     idx_r, idx_nxt;
  logic [WCW-1:0]     word_r, word_nxt;
  logic [PW-1:0]      y_r, y_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [PCW-1:0]     opc_r, opc_nxt;
  logic [PCW-1:0]     ores_r, ores_nxt;
  logic [LEFT_W-1:0]  oleft_r, oleft_nxt;

  // response register
  logic               out_valid_r, out_valid_nxt;
  bpfa_status_t       out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]  out_page_r, out_page_nxt;
  logic [USED_W-1:0]  out_used_r, out_used_nxt;
  logic [LEFT_W-1:0]  out_left_r, out_left_nxt;

  // table update strobes
  logic               tbl_wr;
  logic               hint_wr;

  // map ram
  logic [WORD_W-1:0]  mem [MAP_WORDS];
  logic [WORD_W-1:0]  mem_rdata_r;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_addr;
  logic [WORD_W-1:0]  mem_wdata;

  // number of pages of a above page b, limited to one word
  function automatic logic [6:0] cap64(input logic [PCW-1:0] a, input logic [PCW-1:0] b);
    logic [PCW-1:0] d;
    d = a - b;
    if (a <= b) return 7'd0;
    else if (d >= PCW'(WORD_W)) return 7'd64;
    else return d[6:0];
  endfunction

  logic [RIW-1:0]     cur;
  logic [PCW-1:0]     pbase, pnext;
  logic               in_fire;
  bpfa_op_t           in_op;

  // add decode
  logic [11:0]        a_lo;
  logic [FRAME_W-1:0] a_frame, a_pcf;
  logic [PCW-1:0]     a_pc, a_res;
  logic [27:0]        a_hi;
  logic               a_mid_nz, a_big;
  logic [FRAME_W-1:0] a_resc;

  // alloc / free datapath
  logic [WORD_W-1:0]  fill_word, scan_mask, free_bits;
  logic [5:0]         first_k;
  logic [PCW-1:0]     hit_y;
  logic [FRAME_W-1:0] hit_frame, off;

  assign cur     = idx_r[RIW-1:0];
  assign pbase   = {word_r, 6'b0};
  assign pnext   = pbase + PCW'(WORD_W);
  assign in_op   = bpfa_op_t'(in_chan.opcode);
  assign in_fire = in_chan.valid && in_chan.ready;

  assign in_chan.ready           = (state_r == S_IDLE) && !out_valid_r;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.page_address   = out_page_r;
  assign out_chan.used_pages     = out_used_r;
  assign out_chan.leftover_bytes = out_left_r;

  // region geometry from the add request
  always_comb begin
    a_lo     = in_chan.address[11:0];
    a_frame  = in_chan.address[ADDR_W-1:PAGE_SHIFT] + FRAME_W'(a_lo != 12'd0);
    a_pcf    = in_chan.length[LEN_W-1:PAGE_SHIFT];
    a_pc     = (a_pcf > FRAME_W'(REGION_PAGES)) ? PCW'(REGION_PAGES) : a_pcf[PCW-1:0];
    a_hi     = in_chan.length[51:24];
    a_mid_nz = in_chan.length[23:12] != 12'd0;
    a_big    = (a_hi > 28'd1) || ((a_hi == 28'd1) && a_mid_nz);
    a_resc   = a_big ? (FRAME_W'(a_hi) + FRAME_W'(a_mid_nz)) : FRAME_W'(1);
    a_res    = (a_resc > FRAME_W'(a_pc)) ? a_pc : a_resc[PCW-1:0];
  end

  // word masks and first free bit
  always_comb begin
    fill_word = ~(ONES << cap64(ores_r, pbase));
    scan_mask = (ONES << cap64(PCW'(hint_r[cur]), pbase)) &
                ~(ONES << cap64(pcnt_r[cur], pbase));
    free_bits = ~mem_rdata_r & scan_mask;
    first_k   = 6'd0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (free_bits[k]) first_k = 6'(k);
    end
    hit_y     = pbase + PCW'(first_k);
    hit_frame = base_r[cur] + FRAME_W'(hit_y);
    off       = frame_r - base_r[cur];
  end

  // sequencer: next state, ram access and response
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    word_nxt       = word_r;
    y_nxt          = y_r;
    frame_nxt      = frame_r;
    opc_nxt        = opc_r;
    ores_nxt       = ores_r;
    oleft_nxt      = oleft_r;
    nreg_nxt       = nreg_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_used_nxt   = out_used_r;
    out_left_nxt   = out_left_r;
    tbl_wr         = 1'b0;
    hint_wr        = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = AW'(cur) * AW'(WPR) + AW'(word_r);
    mem_wdata      = fill_word;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          idx_nxt      = '0;
          word_nxt     = '0;
          frame_nxt    = in_chan.address[ADDR_W-1:PAGE_SHIFT];
          out_status_nxt = ST_OK;
          out_page_nxt = '0;
          out_left_nxt = '0;
          out_used_nxt = USED_W'(total_r);
          unique case (in_op)
            OP_ADD: begin
              if (nreg_r >= RCW'(MAX_REGIONS)) begin
                out_status_nxt = ST_TABLE_FULL;
                out_valid_nxt  = 1'b1;
              end else begin
                idx_nxt   = nreg_r;
                frame_nxt = a_frame;
                opc_nxt   = a_pc;
                ores_nxt  = a_res;
                oleft_nxt = LEFT_W'(a_lo) + LEFT_W'(in_chan.length[11:0]);
                state_nxt = S_ADD_FILL;
              end
            end
            OP_ALLOC: state_nxt = S_ALLOC_REGION;
            OP_FREE:  state_nxt = S_FREE_SCAN;
            OP_COUNT: out_valid_nxt = 1'b1;
            default:  out_valid_nxt = 1'b1;
          endcase
        end
      end

      // rewrite every word of the new region, reserved pages set
      S_ADD_FILL: begin
        mem_we   = 1'b1;
        word_nxt = word_r + WCW'(1);
        if (word_r == WCW'(WPR - 1)) begin
          tbl_wr         = 1'b1;
          nreg_nxt       = nreg_r + RCW'(1);
          total_nxt      = total_r + TW'(ores_r);
          out_left_nxt   = oleft_r;
          out_used_nxt   = USED_W'(total_nxt);
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      // pick the next region with pages above its hint
      S_ALLOC_REGION: begin
        if (idx_r >= nreg_r) begin
          out_status_nxt = ST_NO_FREE;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (PCW'(hint_r[cur]) >= pcnt_r[cur]) begin
          idx_nxt = idx_r + RCW'(1);
        end else begin
          word_nxt  = WCW'(hint_r[cur] >> 6);
          state_nxt = S_ALLOC_READ;
        end
      end

      S_ALLOC_READ: begin
        mem_re    = 1'b1;
        state_nxt = S_ALLOC_CHECK;
      end

      // take the lowest free page of the word, or move on
      S_ALLOC_CHECK: begin
        if (free_bits != '0) begin
          mem_we         = 1'b1;
          mem_wdata      = mem_rdata_r | (WORD_W'(1) << first_k);
          total_nxt      = total_r + TW'(1);
          out_page_nxt   = {hit_frame, {PAGE_SHIFT{1'b0}}};
          out_used_nxt   = USED_W'(total_nxt);
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (pnext >= pcnt_r[cur]) begin
          idx_nxt   = idx_r + RCW'(1);
          state_nxt = S_ALLOC_REGION;
        end else begin
          word_nxt  = word_r + WCW'(1);
          state_nxt = S_ALLOC_READ;
        end
      end

      // find the first region whose unreserved pages hold the frame
      S_FREE_SCAN: begin
        if (idx_r >= nreg_r) begin
          out_status_nxt = ST_NOT_FOUND;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (off >= FRAME_W'(resv_r[cur]) && off < FRAME_W'(pcnt_r[cur])) begin
          y_nxt     = off[PW-1:0];
          word_nxt  = WCW'(off[PW-1:0] >> 6);
          state_nxt = S_FREE_READ;
        end else begin
          idx_nxt = idx_r + RCW'(1);
        end
      end

      S_FREE_READ: begin
        mem_re    = 1'b1;
        state_nxt = S_FREE_WRITE;
      end

      // clear the bit, lower the hint
      S_FREE_WRITE: begin
        if (mem_rdata_r[y_r[5:0]]) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata_r & ~(WORD_W'(1) << y_r[5:0]);
          total_nxt = total_r - TW'(1);
        end
        hint_wr       = y_r < hint_r[cur];
        out_used_nxt  = USED_W'(total_nxt);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control and table registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nreg_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_REGIONS; i++) begin
        base_r[i] <= '0;
        pcnt_r[i] <= '0;
        resv_r[i] <= '0;
        hint_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      nreg_r      <= nreg_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (tbl_wr) begin
        base_r[cur] <= frame_r;
        pcnt_r[cur] <= opc_r;
        resv_r[cur] <= ores_r;
        hint_r[cur] <= '0;
      end
      if (hint_wr) hint_r[cur] <= y_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    word_r       <= word_nxt;
    y_r          <= y_nxt;
    frame_r      <= frame_nxt;
    opc_r        <= opc_nxt;
    ores_r       <= ores_nxt;
    oleft_r      <= oleft_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_used_r   <= out_used_nxt;
    out_left_r   <= out_left_nxt;
  end

  // used-bit map ram, single port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem[mem_addr];
  end

endmodule
